[rtl/core/isa_pkg.sv]
// ----------------------------------------------------------------------------
// isa_pkg
// Types and constants shared by the interval seat allocator.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int NUM_SEATS  = 32;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 24;
  localparam int SEAT_W     = $clog2(NUM_SEATS);
  localparam int OPEN_W     = $clog2(NUM_SEATS + 1);

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic                 last_item;
  } isa_in_t;

  typedef struct packed {
    logic [SEAT_W-1:0]     seat_index;
    logic [COUNT_BITS-1:0] use_count;
    logic [OPEN_W-1:0]     seats_opened;
    logic                  is_summary;
    logic                  all_busy;
    logic                  last_of_run;
  } isa_out_t;

  typedef enum logic {
    ST_ASSIGN,
    ST_READOUT
  } isa_state_t;

endpackage

[rtl/core/interval_seat_allocator.sv]
// ----------------------------------------------------------------------------
// interval_seat_allocator
// Lowest-free-index interval partitioning over a bank of seat registers,
// with a per-seat summary readout after the item marked last.
// ----------------------------------------------------------------------------
// path: the result register loads from the input register when the word
//   advances, which waits while out_stall holds or during the summary readout
// throughput: one interval per cycle unless out_stall holds; a last item adds
//   a summary word per opened seat; assignments wait on the readout counter
// reset: clears control state and the opened-seat count; seat registers are
//   not cleared, no clearing pass
module interval_seat_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  isa_pkg::isa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output isa_pkg::isa_out_t out_data
);

  localparam int N  = isa_pkg::NUM_SEATS;
  localparam int SW = isa_pkg::SEAT_W;
  localparam int OW = isa_pkg::OPEN_W;
  localparam int CW = isa_pkg::COUNT_BITS;
  localparam int TW = isa_pkg::TIME_BITS;

  // input register
  logic              a_vld_r;
  isa_pkg::isa_in_t  a_data_r;

  // result register
  logic              out_vld_r;
  isa_pkg::isa_out_t out_data_r;

  // seat bank
  logic [TW-1:0]     seat_end_r  [N];
  logic [CW-1:0]     seat_uses_r [N];
  logic [OW-1:0]     opened_r;
  logic [SW-1:0]     rd_idx_r;
  isa_pkg::isa_state_t state_r;

  logic [OW-1:0]     opened_nxt;
  logic [SW-1:0]     rd_idx_nxt;
  isa_pkg::isa_state_t state_nxt;
  isa_pkg::isa_out_t out_nxt;
  logic              out_load;
  logic              a_adv;
  logic              slot_free;
  logic              sum_last;

  logic [N-1:0]      free_vec;
  logic [N-1:0]      first_free;
  logic              found;
  logic [SW-1:0]     pick;
  logic              can_open;
  logic [SW-1:0]     use_idx;
  logic [CW-1:0]     use_rd;
  logic [CW-1:0]     use_new;
  logic              wr_en;
  logic [SW-1:0]     wr_idx;

  // parallel compare of every opened seat against the start time
  always_comb begin
    for (int i = 0; i < N; i++) begin
      free_vec[i] = (OW'(i) < opened_r) && (seat_end_r[i] <= a_data_r.start_time);
    end
  end

  // isolate lowest set bit, then encode
  assign first_free = free_vec & (~free_vec + N'(1));
  assign found      = |free_vec;

  always_comb begin
    pick = '0;
    for (int i = 0; i < N; i++) begin
      if (first_free[i]) begin
        pick = pick | SW'(i);
      end
    end
  end

  assign can_open = (opened_r < OW'(N));
  assign use_idx  = (state_r == isa_pkg::ST_READOUT) ? rd_idx_r : pick;
  assign use_rd   = seat_uses_r[use_idx];
  assign sum_last = ({1'b0, rd_idx_r} == OW'(opened_r - OW'(1)));

  assign slot_free = !out_vld_r || !out_stall;
  assign a_adv     = a_vld_r && slot_free && (state_r == isa_pkg::ST_ASSIGN);
  assign in_stall  = a_vld_r && !a_adv;

  always_comb begin
    state_nxt  = state_r;
    opened_nxt = opened_r;
    rd_idx_nxt = rd_idx_r;
    out_load   = 1'b0;
    out_nxt    = out_data_r;
    wr_en      = 1'b0;
    wr_idx     = pick;
    use_new    = use_rd;
    case (state_r)
      isa_pkg::ST_ASSIGN: begin
        if (a_adv) begin
          out_load = 1'b1;
          out_nxt.is_summary  = 1'b0;
          out_nxt.last_of_run = !a_data_r.last_item;
          if (found) begin
            wr_en   = 1'b1;
            use_new = (use_rd == {CW{1'b1}}) ? use_rd : CW'(use_rd + CW'(1));
          end else if (can_open) begin
            wr_en      = 1'b1;
            wr_idx     = opened_r[SW-1:0];
            use_new    = CW'(1);
            opened_nxt = OW'(opened_r + OW'(1));
          end
          out_nxt.seat_index   = wr_en ? wr_idx : '0;
          out_nxt.use_count    = wr_en ? use_new : '0;
          out_nxt.all_busy     = !wr_en;
          out_nxt.seats_opened = opened_nxt;
          if (a_data_r.last_item) begin
            state_nxt  = isa_pkg::ST_READOUT;
            rd_idx_nxt = '0;
          end
        end
      end
      isa_pkg::ST_READOUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt.seat_index   = rd_idx_r;
          out_nxt.use_count    = use_rd;
          out_nxt.seats_opened = opened_r;
          out_nxt.is_summary   = 1'b1;
          out_nxt.all_busy     = 1'b0;
          out_nxt.last_of_run  = sum_last;
          rd_idx_nxt = SW'(rd_idx_r + SW'(1));
          if (sum_last) begin
            state_nxt  = isa_pkg::ST_ASSIGN;
            opened_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = isa_pkg::ST_ASSIGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= isa_pkg::ST_ASSIGN;
      opened_r  <= '0;
      rd_idx_r  <= '0;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      opened_r <= opened_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (!in_stall) begin
        a_vld_r <= in_valid;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
    if (wr_en) begin
      seat_end_r[wr_idx]  <= a_data_r.end_time;
      seat_uses_r[wr_idx] <= use_new;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_readout_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isa_pkg::ST_READOUT |-> opened_r != '0)
    else $error("readout with no opened seat");

  a_opened_bound: assert property (@(posedge clk) disable iff (!rst_n)
    opened_r <= OW'(N))
    else $error("opened count beyond seat bank");

  a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_free) && (found == (first_free != '0)))
    else $error("free seat select not one-hot");

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isa_pkg::ST_READOUT && slot_free && sum_last)
      |=> (opened_r == '0 && state_r == isa_pkg::ST_ASSIGN))
    else $error("seat bank not cleared after summary");

  a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isa_pkg::ST_READOUT |-> !wr_en && !a_adv)
    else $error("seat write during summary readout");

endmodule
